// ===== hw/rtl/dsrd_pkg.sv =====
package dsrd_pkg;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STATE_FORMAT,
		REG_CODE_ENCODING
	} cfg_reg_t;

	localparam logic [1:0] FMT_CLASSIC  = 2'd0;
	localparam logic [1:0] FMT_NEW      = 2'd1;
	localparam logic [1:0] CODE_VARINT  = 2'd3;

	localparam logic [1:0] RESET_STATE_FORMAT  = FMT_CLASSIC;
	localparam logic [1:0] RESET_CODE_ENCODING = 2'd1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_HEADER_MORE,
		PH_CODE_FIXED,
		PH_CODE_VAR
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bytes_seen;
		logic [2:0]  field_length;
		logic [31:0] acc;
		logic        held_final;
		logic [30:0] held_count;
	} dec_state_t;

	typedef struct packed {
		logic        is_final;
		logic [30:0] transition_count;
		logic        code_present;
		logic [31:0] code_value;
	} result_t;

	typedef struct packed {
		logic [1:0] state_format;
		logic [1:0] code_encoding;
	} cfg_t;

	localparam dec_state_t STATE_RESET = '{
		phase:        PH_HEADER,
		bytes_seen:   3'd0,
		field_length: 3'd0,
		acc:          32'd0,
		held_final:   1'b0,
		held_count:   31'd0
	};

endpackage

// ===== hw/rtl/dsrd_step.sv =====
module dsrd_step (
	input  dsrd_pkg::dec_state_t cur,
	input  dsrd_pkg::cfg_t       cfg,
	input  logic [7:0]           in_byte,
	output dsrd_pkg::dec_state_t nxt,
	output logic                 emit,
	output dsrd_pkg::result_t    res
);

	logic        hdr_done;
	logic        hdr_fin;
	logic [30:0] hdr_cnt;
	logic        code_done;
	logic [31:0] code_v;
	logic [31:0] more_acc;
	logic [31:0] more_bits;
	logic [2:0]  more_bs;
	logic        more_done;
	logic [2:0]  first_len;
	logic [31:0] fixed_acc;
	logic        is_classic;

	always_comb begin
		is_classic = (cfg.state_format == dsrd_pkg::FMT_CLASSIC);
		first_len  = in_byte[7:5] - 3'd2;
		unique case (cur.bytes_seen)
			3'd1:    more_bits = {19'd0, in_byte, 5'd0};
			3'd2:    more_bits = {11'd0, in_byte, 13'd0};
			3'd3:    more_bits = {3'd0, in_byte, 21'd0};
			3'd4:    more_bits = {in_byte[2:0], 29'd0};
			default: more_bits = 32'd0;
		endcase
		more_acc  = cur.acc | more_bits;
		more_bs   = cur.bytes_seen + 3'd1;
		more_done = (more_bs >= cur.field_length);
		fixed_acc = {cur.acc[23:0], in_byte};

		nxt       = cur;
		emit      = 1'b0;
		res       = '0;
		hdr_done  = 1'b0;
		hdr_fin   = 1'b0;
		hdr_cnt   = 31'd0;
		code_done = 1'b0;
		code_v    = 32'd0;

		unique case (cur.phase)
			dsrd_pkg::PH_HEADER: begin
				if (is_classic) begin
					nxt.acc          = {24'd0, in_byte};
					nxt.bytes_seen   = 3'd1;
					nxt.field_length = 3'd2;
					nxt.phase        = dsrd_pkg::PH_HEADER_MORE;
				end else if (!in_byte[7]) begin
					hdr_done = 1'b1;
					hdr_fin  = in_byte[0];
					hdr_cnt  = {24'd0, in_byte[7:1]};
				end else begin
					nxt.acc          = {27'd0, in_byte[4:0]};
					nxt.bytes_seen   = 3'd1;
					nxt.field_length = first_len;
					nxt.phase        = dsrd_pkg::PH_HEADER_MORE;
				end
			end
			dsrd_pkg::PH_HEADER_MORE: begin
				if (is_classic) begin
					hdr_done = 1'b1;
					hdr_fin  = !cur.acc[7];
					hdr_cnt  = {16'd0, cur.acc[6:0], in_byte};
				end else begin
					nxt.acc        = more_acc;
					nxt.bytes_seen = more_bs;
					if (more_done) begin
						hdr_done = 1'b1;
						hdr_fin  = more_acc[0];
						hdr_cnt  = more_acc[31:1];
					end
				end
			end
			dsrd_pkg::PH_CODE_FIXED: begin
				nxt.acc        = fixed_acc;
				nxt.bytes_seen = more_bs;
				if (more_done) begin
					code_done = 1'b1;
					code_v    = fixed_acc;
				end
			end
			dsrd_pkg::PH_CODE_VAR: begin
				if (cur.bytes_seen == 3'd0) begin
					if (!in_byte[7]) begin
						code_done = 1'b1;
						code_v    = {24'd0, in_byte};
					end else begin
						nxt.acc          = {27'd0, in_byte[4:0]};
						nxt.bytes_seen   = 3'd1;
						nxt.field_length = first_len;
					end
				end else begin
					nxt.acc        = more_acc;
					nxt.bytes_seen = more_bs;
					if (more_done) begin
						code_done = 1'b1;
						code_v    = more_acc;
					end
				end
			end
			default: nxt = cur;
		endcase

		if (hdr_done) begin
			nxt.bytes_seen = 3'd0;
			nxt.acc        = 32'd0;
			if (hdr_fin && (cfg.state_format == dsrd_pkg::FMT_CLASSIC
					|| cfg.state_format == dsrd_pkg::FMT_NEW)) begin
				nxt.held_final = 1'b1;
				nxt.held_count = hdr_cnt;
				if (cfg.code_encoding == dsrd_pkg::CODE_VARINT) begin
					nxt.field_length = 3'd0;
					nxt.phase        = dsrd_pkg::PH_CODE_VAR;
				end else begin
					nxt.field_length = {1'b0, cfg.code_encoding} + 3'd2;
					nxt.phase        = dsrd_pkg::PH_CODE_FIXED;
				end
			end else begin
				emit                 = 1'b1;
				res.is_final         = hdr_fin;
				res.transition_count = hdr_cnt;
				nxt.field_length     = 3'd0;
				nxt.phase            = dsrd_pkg::PH_HEADER;
			end
		end

		if (code_done) begin
			emit                 = 1'b1;
			res.is_final         = cur.held_final;
			res.transition_count = cur.held_count;
			res.code_present     = 1'b1;
			res.code_value       = code_v;
			nxt                  = dsrd_pkg::STATE_RESET;
		end
	end

endmodule

// ===== hw/rtl/dict_state_record_decoder.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_byte
// out       out_valid / out_ready  is_final, transition_count, code_present, code_value
// config    cfg_we                 cfg_index, cfg_data
//
// One byte is taken in every cycle unless a stalled output holds one back; results are registered.
// The byte register feeds one pass of decode logic that updates the record state.
// A stalled output only holds back bytes that complete a record; others pass on.
// Reset clears the record state and both valid flags and sets the configuration registers
// to their defaults.
module dict_state_record_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            in_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  is_final,
	output logic [30:0]                           transition_count,
	output logic                                  code_present,
	output logic [31:0]                           code_value,
	input  logic                                  cfg_we,
	input  logic [dsrd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dsrd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	dsrd_pkg::cfg_t       cfg_q;
	dsrd_pkg::dec_state_t state_q;
	dsrd_pkg::dec_state_t state_nxt;
	dsrd_pkg::result_t    res;
	dsrd_pkg::result_t    res_q;
	logic                 res_valid_q;
	logic [7:0]           byte_s1;
	logic                 valid_s1;
	logic                 emit;
	logic                 out_free;
	logic                 move_s1;

	dsrd_step u_step (
		.cur     (state_q),
		.cfg     (cfg_q),
		.in_byte (byte_s1),
		.nxt     (state_nxt),
		.emit    (emit),
		.res     (res)
	);

	assign out_free = !res_valid_q || out_ready;
	assign move_s1  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_format  <= dsrd_pkg::RESET_STATE_FORMAT;
			cfg_q.code_encoding <= dsrd_pkg::RESET_CODE_ENCODING;
		end else if (cfg_we) begin
			unique case (dsrd_pkg::cfg_reg_t'(cfg_index))
				dsrd_pkg::REG_STATE_FORMAT:  cfg_q.state_format  <= cfg_data;
				dsrd_pkg::REG_CODE_ENCODING: cfg_q.code_encoding <= cfg_data;
				default:                     cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsrd_pkg::STATE_RESET;
		end else if (move_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && emit) begin
			res_q <= res;
		end
	end

	assign out_valid        = res_valid_q;
	assign is_final         = res_q.is_final;
	assign transition_count = res_q.transition_count;
	assign code_present     = res_q.code_present;
	assign code_value       = res_q.code_value;

endmodule

// ===== hw/rtl/dsrd_checker.sv =====
module dsrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_final,
	input logic [30:0] transition_count,
	input logic        code_present,
	input logic [31:0] code_value
);

	// A result left waiting keeps its whole payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_final)
			&& $stable(transition_count) && $stable(code_present) && $stable(code_value))
	else $error("result changed while stalled");

	// Only a final record carries a code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_present |-> is_final)
	else $error("code on a non-final record");

	// A result without a code reports a zero code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !code_present |-> code_value == 32'd0)
	else $error("code value set without a code");

	// With no result waiting, the block always takes the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
	else $error("input held back with an empty output");

endmodule

bind dict_state_record_decoder dsrd_checker u_dsrd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.is_final         (is_final),
	.transition_count (transition_count),
	.code_present     (code_present),
	.code_value       (code_value)
);

// ===== verif/dict_state_record_decoder_test.sv =====
module dict_state_record_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FMT_BIN2 = 2'd2;
	localparam logic [1:0] FMT_SPARE = 2'd3;
	localparam logic [1:0] CODE_TWO_BYTES = 2'd0;
	localparam logic [1:0] CODE_THREE_BYTES = 2'd1;
	localparam logic [1:0] CODE_FOUR_BYTES = 2'd2;

	localparam int RANDOM_ITEMS = 1250;
	localparam int QUIET_ITEMS = 150;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]        fmt;
		logic [1:0]        enc;
		logic [7:0]        data;
		logic              typed;
		dsrd_pkg::result_t want;
	} stim_row_t;

	localparam dsrd_pkg::result_t ANY = '0;

	localparam stim_row_t record_table [25] = '{
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'hFF, 1'b0, ANY},
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'hFF, 1'b1,
			'{1'b0, 31'h7fff, 1'b0, 32'h0}},
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'h00, 1'b0, ANY},
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'h05, 1'b0, ANY},
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'hAB, 1'b0, ANY},
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'hCD, 1'b0, ANY},
		'{dsrd_pkg::FMT_CLASSIC, CODE_THREE_BYTES, 8'hEF, 1'b1,
			'{1'b1, 31'd5, 1'b1, 32'hABCDEF}},
		'{dsrd_pkg::FMT_NEW, CODE_FOUR_BYTES, 8'h7F, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, CODE_FOUR_BYTES, 8'hFF, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, CODE_FOUR_BYTES, 8'hFF, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, CODE_FOUR_BYTES, 8'hFF, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, CODE_FOUR_BYTES, 8'hFF, 1'b1,
			'{1'b1, 31'h3f, 1'b1, 32'hFFFFFFFF}},
		'{dsrd_pkg::FMT_NEW, CODE_FOUR_BYTES, 8'h00, 1'b1, '{1'b0, 31'd0, 1'b0, 32'h0}},
		'{dsrd_pkg::FMT_NEW, dsrd_pkg::CODE_VARINT, 8'h01, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, dsrd_pkg::CODE_VARINT, 8'h9F, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, dsrd_pkg::CODE_VARINT, 8'hFF, 1'b1,
			'{1'b1, 31'd0, 1'b1, 32'h1FFF}},
		'{dsrd_pkg::FMT_NEW, CODE_TWO_BYTES, 8'h03, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, CODE_TWO_BYTES, 8'h12, 1'b0, ANY},
		'{dsrd_pkg::FMT_NEW, CODE_TWO_BYTES, 8'h34, 1'b1, '{1'b1, 31'd1, 1'b1, 32'h1234}},
		'{FMT_BIN2, CODE_TWO_BYTES, 8'hFF, 1'b0, ANY},
		'{FMT_BIN2, CODE_TWO_BYTES, 8'hFF, 1'b0, ANY},
		'{FMT_BIN2, CODE_TWO_BYTES, 8'hFF, 1'b0, ANY},
		'{FMT_BIN2, CODE_TWO_BYTES, 8'hFF, 1'b0, ANY},
		'{FMT_BIN2, CODE_TWO_BYTES, 8'hFF, 1'b1, '{1'b1, 31'h7fffffff, 1'b0, 32'h0}},
		'{FMT_SPARE, CODE_TWO_BYTES, 8'h01, 1'b1, '{1'b1, 31'd0, 1'b0, 32'h0}}
	};

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [7:0]                       in_byte = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             is_final;
	logic [30:0]                      transition_count;
	logic                             code_present;
	logic [31:0]                      code_value;
	logic                             cfg_we = 1'b0;
	logic [dsrd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [dsrd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	dict_state_record_decoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.is_final         (is_final),
		.transition_count (transition_count),
		.code_present     (code_present),
		.code_value       (code_value),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [1:0]       cur_fmt = dsrd_pkg::RESET_STATE_FORMAT;
	logic [1:0]       cur_enc = dsrd_pkg::RESET_CODE_ENCODING;
	dsrd_pkg::phase_t rec_phase = dsrd_pkg::PH_HEADER;
	logic [2:0]       rec_seen = '0;
	logic [2:0]       rec_len = '0;
	logic [31:0]      rec_acc = '0;
	logic             rec_final = 1'b0;
	logic [30:0]      rec_count = '0;

	dsrd_pkg::result_t awaited_records [$];
	logic [7:0]        record_bytes [$];
	int                bytes_sent = 0;
	int                mismatches = 0;
	int                cycle_count = 0;
	bit                idle_on = 1'b1;
	bit                long_hold = 1'b0;

	function automatic void clear_fields();
		rec_seen = '0;
		rec_len = '0;
		rec_acc = '0;
	endfunction

	function automatic bit close_header(input logic fin, input logic [30:0] count,
			output dsrd_pkg::result_t res);
		res = '0;
		if (fin && (cur_fmt == dsrd_pkg::FMT_CLASSIC || cur_fmt == dsrd_pkg::FMT_NEW)) begin
			rec_final = 1'b1;
			rec_count = count;
			clear_fields();
			if (cur_enc == dsrd_pkg::CODE_VARINT) begin
				rec_phase = dsrd_pkg::PH_CODE_VAR;
			end else begin
				rec_phase = dsrd_pkg::PH_CODE_FIXED;
				rec_len = {1'b0, cur_enc} + 3'd2;
			end
			return 1'b0;
		end
		res = '{is_final: fin, transition_count: count, code_present: 1'b0, code_value: 32'h0};
		rec_phase = dsrd_pkg::PH_HEADER;
		clear_fields();
		return 1'b1;
	endfunction

	function automatic bit close_code(input logic [31:0] code, output dsrd_pkg::result_t res);
		res = '{is_final: rec_final, transition_count: rec_count, code_present: 1'b1,
			code_value: code};
		rec_phase = dsrd_pkg::PH_HEADER;
		clear_fields();
		rec_final = 1'b0;
		rec_count = '0;
		return 1'b1;
	endfunction

	// A first byte with the top bit clear is a whole value; otherwise its top three bits, less two,
	// give the length in bytes.
	function automatic bit varint_start(input logic [7:0] b);
		if (!b[7]) begin
			rec_acc = {24'b0, b};
			return 1'b1;
		end
		rec_acc = {27'b0, b[4:0]};
		rec_len = b[7:5] - 3'd2;
		rec_seen = 3'd1;
		return 1'b0;
	endfunction

	function automatic bit varint_next(input logic [7:0] b);
		int sh;
		sh = 8 * int'(rec_seen) - 3;
		if (rec_seen >= 3'd1 && rec_seen <= 3'd4)
			rec_acc = rec_acc | ({24'b0, b} << sh);
		rec_seen = rec_seen + 3'd1;
		return rec_seen >= rec_len;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output dsrd_pkg::result_t res);
		res = '0;
		case (rec_phase)
			dsrd_pkg::PH_HEADER: begin
				if (cur_fmt == dsrd_pkg::FMT_CLASSIC) begin
					rec_acc = {24'b0, b};
					rec_seen = 3'd1;
					rec_len = 3'd2;
					rec_phase = dsrd_pkg::PH_HEADER_MORE;
					return 1'b0;
				end
				if (varint_start(b))
					return close_header(rec_acc[0], rec_acc[31:1], res);
				rec_phase = dsrd_pkg::PH_HEADER_MORE;
				return 1'b0;
			end
			dsrd_pkg::PH_HEADER_MORE: begin
				if (cur_fmt == dsrd_pkg::FMT_CLASSIC)
					return close_header(!rec_acc[7], {16'b0, rec_acc[6:0], b}, res);
				if (varint_next(b))
					return close_header(rec_acc[0], rec_acc[31:1], res);
				return 1'b0;
			end
			dsrd_pkg::PH_CODE_FIXED: begin
				rec_acc = {rec_acc[23:0], b};
				rec_seen = rec_seen + 3'd1;
				if (rec_seen >= rec_len)
					return close_code(rec_acc, res);
				return 1'b0;
			end
			default: begin
				if (rec_seen == 3'd0) begin
					if (varint_start(b))
						return close_code(rec_acc, res);
					return 1'b0;
				end
				if (varint_next(b))
					return close_code(rec_acc, res);
				return 1'b0;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic logic [7:0] push_varint();
		int n;
		logic [7:0] head;
		n = $urandom_range(1, 5);
		if (n == 1) begin
			head = {1'b0, 7'($urandom)};
			record_bytes.push_back(head);
		end else begin
			head = {3'(n + 2), 5'($urandom)};
			record_bytes.push_back(head);
			repeat (n - 1) record_bytes.push_back(8'($urandom));
		end
		return head;
	endfunction

	function automatic void queue_record();
		logic [7:0] head;
		logic fin;
		if (cur_fmt == dsrd_pkg::FMT_CLASSIC) begin
			head = 8'($urandom);
			record_bytes.push_back(head);
			record_bytes.push_back(8'($urandom));
			fin = !head[7];
		end else begin
			head = push_varint();
			fin = head[0];
		end
		if (fin && (cur_fmt == dsrd_pkg::FMT_CLASSIC || cur_fmt == dsrd_pkg::FMT_NEW)) begin
			if (cur_enc == dsrd_pkg::CODE_VARINT)
				void'(push_varint());
			else
				repeat (int'(cur_enc) + 2) record_bytes.push_back(8'($urandom));
		end
	endfunction

	task automatic send_byte(input logic [7:0] data, input bit typed,
			input dsrd_pkg::result_t want);
		int gap;
		bit has_result;
		dsrd_pkg::result_t res;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		has_result = decode_byte(data, res);
		if (typed)
			awaited_records.push_back(want);
		else if (has_result)
			awaited_records.push_back(res);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_records.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] fmt, input logic [1:0] enc);
		cfg_we <= 1'b1;
		cfg_index <= dsrd_pkg::REG_STATE_FORMAT;
		cfg_data <= fmt;
		@(posedge clk);
		cfg_index <= dsrd_pkg::REG_CODE_ENCODING;
		cfg_data <= enc;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_fmt = fmt;
		cur_enc = enc;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		dsrd_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_records.size() == 0) begin
				$display("%0t ns: result expected none, got final %0b count %0h code %0b/%0h",
					$time, is_final, transition_count, code_present, code_value);
				mismatches++;
			end else begin
				want = awaited_records.pop_front();
				check_field("is_final", 32'(want.is_final), 32'(is_final));
				check_field("transition_count", 32'(want.transition_count),
					32'(transition_count));
				check_field("code_present", 32'(want.code_present), 32'(code_present));
				check_field("code_value", want.code_value, code_value);
			end
		end
	end

	initial begin
		int gap;
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 6);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int phase_count;
		int phase_start;
		int phase_budget;
		int total_items;
		phase_count = 0;
		total_items = $size(record_table) + RANDOM_ITEMS;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (record_table[i]) begin
			if (record_table[i].fmt != cur_fmt || record_table[i].enc != cur_enc) begin
				wait_idle();
				set_config(record_table[i].fmt, record_table[i].enc);
			end
			send_byte(record_table[i].data, record_table[i].typed, record_table[i].want);
		end

		while (bytes_sent < total_items) begin
			wait_idle();
			set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			idle_on = ($urandom_range(0, 3) != 0);
			// The receiver stalls for a long stretch while bytes keep coming.
			if (phase_count == 2) begin
				long_hold = 1'b1;
				idle_on = 1'b0;
			end
			if (bytes_sent >= total_items - QUIET_ITEMS)
				idle_on = 1'b0;
			phase_start = bytes_sent;
			phase_budget = $urandom_range(40, 120);
			while (bytes_sent - phase_start < phase_budget) begin
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3)) record_bytes.push_back(8'($urandom));
				else
					queue_record();
				while (record_bytes.size() != 0)
					send_byte(record_bytes.pop_front(), 1'b0, ANY);
			end
			phase_count++;
		end

		wait_idle();
		if (mismatches == 0 && awaited_records.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dsrd_pkg.sv
hw/rtl/dsrd_step.sv
hw/rtl/dict_state_record_decoder.sv
hw/rtl/dsrd_checker.sv
verif/dict_state_record_decoder_test.sv
